@@ rtl/core/adaptive_compute_path_selector_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the compute path selector
// Shared check forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_COMPUTE_PATH_SELECTOR_MACROS_SVH
`define ADAPTIVE_COMPUTE_PATH_SELECTOR_MACROS_SVH

// same-cycle implication
`define ACPS_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define ACPS_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/core/acps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acps_pkg
// Types and constants shared by the compute path selector modules.
// ----------------------------------------------------------------------------
package acps_pkg;

  typedef enum logic [1:0] {
    FN_SELECT = 2'd0,
    FN_RECORD = 2'd1,
    FN_FORCE  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PATH_TILE      = 3'd0,
    PATH_WIDE_DOT  = 3'd1,
    PATH_WIDE_FMA  = 3'd2,
    PATH_NARROW    = 3'd3,
    PATH_SCALAR    = 3'd4,
    PATH_GPU       = 3'd5
  } path_t;

  typedef enum logic [1:0] {
    CFG_FEATURE_MASK = 2'd0,
    CFG_TILE_MIN     = 2'd1,
    CFG_DOT_MIN      = 2'd2,
    CFG_WIDE_MIN     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DIV,
    BK_FIX
  } back_state_t;

  // feature mask bits
  localparam int unsigned FM_TILE = 0;
  localparam int unsigned FM_BF16 = 1;
  localparam int unsigned FM_WIDE = 2;
  localparam int unsigned FM_DOT  = 3;

  localparam logic [2:0] WT_QK = 3'd0;
  localparam logic [2:0] WT_UP = 3'd2;

  localparam logic [31:0] TILE_MIN_RST = 32'd1024;
  localparam logic [31:0] DOT_MIN_RST  = 32'd512;
  localparam logic [31:0] WIDE_MIN_RST = 32'd256;

  localparam logic [15:0] RATE_ONE    = 16'd65535;
  localparam logic [15:0] RATE_GATE   = 16'd62259;
  localparam logic [15:0] COUNT_GATE  = 16'd10;
  localparam logic [15:0] LEARN_COUNT = 16'd20;
  localparam logic [15:0] COUNT_MAX   = 16'd65535;

  // floor(2^32 / d); estimate is exact or one low
  localparam logic [28:0] RECIP10 = 29'd429496729;
  localparam logic [27:0] RECIP20 = 28'd214748364;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    func_t       func;
    logic [2:0]  wtype;
    path_t       pick;
    path_t       upath;
    logic [23:0] lat;
    logic        ok;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    path_t       learned;
    logic [15:0] count;
    logic [15:0] rate;
    logic [23:0] avg;
    logic [23:0] lat_min;
    logic [23:0] lat_max;
  } stats_t;

  typedef struct packed {
    path_t       path;
    logic        from_table;
    logic [15:0] count;
    logic [15:0] rate;
    logic [23:0] avg;
    logic [23:0] lat_min;
    logic [23:0] lat_max;
  } result_t;

endpackage

@@ rtl/core/acps_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acps_front
// Takes requests, holds configuration, runs the feature/size priority chain.
// ----------------------------------------------------------------------------
module acps_front import acps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  func,
  input  logic [2:0]  workload_type,
  input  logic [15:0] batch_size,
  input  logic [15:0] seq_len,
  input  logic [15:0] head_dim,
  input  logic [2:0]  used_path,
  input  logic [23:0] latency,
  input  logic        success,
  input  q_stat_t     q_stat,
  output logic        push,
  output work_t       push_item
);

  logic [4:0]  feature_mask;
  logic [31:0] tile_min_size;
  logic [31:0] dot_min_size;
  logic [31:0] wide_min_size;

  logic        f_valid;
  func_t       f_func;
  logic [2:0]  f_wtype;
  logic [15:0] f_batch;
  logic [31:0] f_size;
  path_t       f_upath;
  logic [23:0] f_lat;
  logic        f_ok;
  logic        accept;
  path_t       pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_mask  <= '0;
      tile_min_size <= TILE_MIN_RST;
      dot_min_size  <= DOT_MIN_RST;
      wide_min_size <= WIDE_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FEATURE_MASK: feature_mask  <= cfg_data[4:0];
        CFG_TILE_MIN:     tile_min_size <= cfg_data;
        CFG_DOT_MIN:      dot_min_size  <= cfg_data;
        CFG_WIDE_MIN:     wide_min_size <= cfg_data;
        default:          feature_mask  <= feature_mask;
      endcase
    end
  end

  assign push   = f_valid && !q_stat.full;
  assign busy   = f_valid && q_stat.full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept || (f_valid && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_func  <= func_t'(func);
      f_wtype <= workload_type;
      f_batch <= batch_size;
      f_size  <= 32'(seq_len) * 32'(head_dim);
      f_upath <= (used_path > 3'(PATH_GPU)) ? PATH_SCALAR : path_t'(used_path);
      f_lat   <= latency;
      f_ok    <= success;
    end
  end

  // tile branch wins on both tile flags even when its own test fails
  always_comb begin
    pick = PATH_NARROW;
    if (feature_mask[FM_TILE] && feature_mask[FM_BF16]) begin
      if (f_size >= tile_min_size && (f_wtype == WT_QK || f_wtype == WT_UP))
        pick = PATH_TILE;
    end else if (feature_mask[FM_DOT]) begin
      if (f_batch > 16'd1 || f_size >= dot_min_size)
        pick = PATH_WIDE_DOT;
    end else if (feature_mask[FM_WIDE]) begin
      if (f_size >= wide_min_size)
        pick = PATH_WIDE_FMA;
    end
  end

  always_comb begin
    push_item.func  = f_func;
    push_item.wtype = f_wtype;
    push_item.pick  = pick;
    push_item.upath = f_upath;
    push_item.lat   = f_lat;
    push_item.ok    = f_ok;
  end

endmodule

@@ rtl/core/acps_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acps_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module acps_queue import acps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  work_t   push_item,
  input  logic    pop,
  output work_t   head_item,
  output q_stat_t q_stat
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= bump(tail);
      if (pop)  head <= bump(head);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[tail] <= push_item;
  end

  assign head_item    = slots[head];
  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

@@ rtl/core/acps_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acps_back
// Per-type statistics store and the read-update-write sequence for requests.
// ----------------------------------------------------------------------------
module acps_back import acps_pkg::*; #(
  parameter int unsigned TYPE_COUNT = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  q_stat_t q_stat,
  input  work_t   head_item,
  output logic    pop,
  output logic    done,
  output result_t result
);

  localparam int unsigned IDX_W = $clog2(TYPE_COUNT);

  back_state_t state, state_next;

  stats_t          mem [TYPE_COUNT];
  logic            stats_valid   [TYPE_COUNT];
  logic            learned_valid [TYPE_COUNT];

  work_t           job;
  logic [IDX_W-1:0] job_idx;
  logic [IDX_W-1:0] head_idx;
  stats_t          rd_entry;
  logic            rd_valid;
  logic            rd_lvalid;

  stats_t          cur;
  stats_t          cur_q;
  logic [27:0]     avg_sum;
  logic [20:0]     rate_sum;
  logic [15:0]     count_new;
  logic [23:0]     min_new;
  logic [23:0]     max_new;
  logic            first;
  logic [23:0]     avg_q0;
  logic [15:0]     rate_q0;
  logic [56:0]     avg_prod;
  logic [48:0]     rate_prod;
  logic [27:0]     avg_rem;
  logic [20:0]     rate_rem;
  logic [23:0]     avg_fin;
  logic [15:0]     rate_fin;
  logic            calc_en;
  logic            div_en;
  logic            fix_en;
  logic            wr_en;
  stats_t          wr_entry;
  logic            learn_set;
  result_t         res_next;

  // workload type modulo TYPE_COUNT, by repeated subtraction on a 3-bit value
  function automatic logic [IDX_W-1:0] type_index(input logic [2:0] w);
    logic [6:0] v;
    v = {4'b0, w};
    for (int i = 0; i < 4; i++) begin
      if (v >= 7'(TYPE_COUNT)) v = v - 7'(TYPE_COUNT);
    end
    return v[IDX_W-1:0];
  endfunction

  assign head_idx = type_index(head_item.wtype);

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    calc_en    = 1'b0;
    div_en     = 1'b0;
    fix_en     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_CALC;
        end
      end
      BK_CALC: begin
        calc_en    = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        div_en     = 1'b1;
        state_next = BK_FIX;
      end
      BK_FIX: begin
        fix_en     = 1'b1;
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // stats memory, registered read
  always_ff @(posedge clk) begin
    if (pop) rd_entry <= mem[head_idx];
    if (wr_en) mem[job_idx] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TYPE_COUNT; i++) begin
        stats_valid[i]   <= 1'b0;
        learned_valid[i] <= 1'b0;
      end
    end else if (wr_en) begin
      stats_valid[job_idx] <= 1'b1;
      if (learn_set) learned_valid[job_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job       <= head_item;
      job_idx   <= head_idx;
      rd_valid  <= stats_valid[head_idx];
      rd_lvalid <= learned_valid[head_idx];
    end
  end

  // unwritten entries read as zero
  assign cur   = rd_valid ? rd_entry : '0;
  assign first = (cur.count == '0);

  always_ff @(posedge clk) begin
    if (calc_en) begin
      cur_q     <= cur;
      avg_sum   <= {1'b0, cur.avg, 3'b0} + 28'(cur.avg) + 28'(job.lat);
      rate_sum  <= 21'({cur.rate, 4'b0}) + 21'({cur.rate, 1'b0}) + 21'(cur.rate)
                   + (job.ok ? 21'(RATE_ONE) : 21'd0);
      count_new <= (cur.count == COUNT_MAX) ? cur.count : cur.count + 16'd1;
      min_new   <= (first || job.lat < cur.lat_min) ? job.lat : cur.lat_min;
      max_new   <= (first || job.lat > cur.lat_max) ? job.lat : cur.lat_max;
    end
  end

  assign avg_prod  = 57'(avg_sum) * 57'(RECIP10);
  assign rate_prod = 49'(rate_sum) * 49'(RECIP20);

  always_ff @(posedge clk) begin
    if (div_en) begin
      avg_q0  <= avg_prod[55:32];
      rate_q0 <= rate_prod[47:32];
    end
  end

  // estimate is at most one low: one compare and step fixes it
  assign avg_rem  = avg_sum - ({1'b0, avg_q0, 3'b0} + {3'b0, avg_q0, 1'b0});
  assign rate_rem = rate_sum - ({1'b0, rate_q0, 4'b0} + {3'b0, rate_q0, 2'b0});
  assign avg_fin  = (avg_rem >= 28'd10) ? avg_q0 + 24'd1 : avg_q0;
  assign rate_fin = (rate_rem >= 21'd20) ? rate_q0 + 16'd1 : rate_q0;

  always_comb begin
    wr_en     = 1'b0;
    learn_set = 1'b0;
    wr_entry  = cur_q;
    res_next.path       = PATH_TILE;
    res_next.from_table = 1'b0;
    res_next.count      = cur_q.count;
    res_next.rate       = cur_q.rate;
    res_next.avg        = cur_q.avg;
    res_next.lat_min    = cur_q.lat_min;
    res_next.lat_max    = cur_q.lat_max;
    case (job.func)
      FN_SELECT: begin
        if (rd_lvalid && cur_q.count > COUNT_GATE && cur_q.rate > RATE_GATE) begin
          res_next.path       = cur_q.learned;
          res_next.from_table = 1'b1;
        end else begin
          res_next.path = job.pick;
        end
      end
      FN_RECORD: begin
        wr_en            = fix_en;
        wr_entry.count   = count_new;
        wr_entry.rate    = rate_fin;
        wr_entry.avg     = cur_q.count == '0 ? job.lat : avg_fin;
        wr_entry.lat_min = min_new;
        wr_entry.lat_max = max_new;
        if (count_new >= LEARN_COUNT) begin
          learn_set        = 1'b1;
          wr_entry.learned = job.upath;
        end
        res_next.path    = job.upath;
        res_next.count   = wr_entry.count;
        res_next.rate    = wr_entry.rate;
        res_next.avg     = wr_entry.avg;
        res_next.lat_min = wr_entry.lat_min;
        res_next.lat_max = wr_entry.lat_max;
      end
      FN_FORCE: begin
        wr_en            = fix_en;
        learn_set        = 1'b1;
        wr_entry.learned = job.upath;
        res_next.path    = job.upath;
      end
      default: res_next.path = PATH_TILE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= fix_en;
  end

  always_ff @(posedge clk) begin
    if (fix_en) result <= res_next;
  end

endmodule

@@ rtl/core/adaptive_compute_path_selector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_compute_path_selector
// Picks a compute path per workload type and learns from recorded outcomes.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. func
//   selects the operation: select a path, record an outcome, or force the
//   learned path. Every request gives exactly one result, shown for a single
//   cycle with done high; there is no back-pressure on the result side.
//   Configuration registers are written through cfg_we / cfg_index /
//   cfg_data, one register per cycle, while no request is in flight.
// Pipeline:
//   A request passes through the front register and the queue; the back end
//   then runs its read, update, divide and write-back sequence on the
//   statistics store and takes the next request only when that is through.
//   The front stage and a two-entry queue absorb up to three requests ahead
//   of the back end; busy rises when all of them are occupied.
// Reset:
//   rst clears the statistics and learned paths (valid bits per type),
//   loads the default configuration and drops any queued requests.
// ----------------------------------------------------------------------------
`include "adaptive_compute_path_selector_macros.svh"

module adaptive_compute_path_selector import acps_pkg::*; #(
  parameter int unsigned TYPE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  func,
  input  logic [2:0]  workload_type,
  input  logic [15:0] batch_size,
  input  logic [15:0] seq_len,
  input  logic [15:0] head_dim,
  input  logic [2:0]  used_path,
  input  logic [23:0] latency,
  input  logic        success,
  output logic        done,
  output logic [2:0]  path,
  output logic        from_table,
  output logic [15:0] sample_count,
  output logic [15:0] rate_avg,
  output logic [23:0] latency_avg,
  output logic [23:0] latency_min,
  output logic [23:0] latency_max
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  work_t   push_item;
  work_t   head_item;
  result_t result;

  acps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (func),
    .workload_type (workload_type),
    .batch_size    (batch_size),
    .seq_len       (seq_len),
    .head_dim      (head_dim),
    .used_path     (used_path),
    .latency       (latency),
    .success       (success),
    .q_stat        (q_stat),
    .push          (q_push),
    .push_item     (push_item)
  );

  acps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  acps_back #(
    .TYPE_COUNT (TYPE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (q_pop),
    .done      (done),
    .result    (result)
  );

  assign path         = 3'(result.path);
  assign from_table   = result.from_table;
  assign sample_count = result.count;
  assign rate_avg     = result.rate;
  assign latency_avg  = result.avg;
  assign latency_min  = result.lat_min;
  assign latency_max  = result.lat_max;

  `ACPS_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "request pushed into full queue")
  `ACPS_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "request popped from empty queue")
  `ACPS_ASSERT_NXT(a_done_spaced, done, !done, "results closer than the back-end sequence")

endmodule
